// ===== rtl/ima_adpcm_block_decoder_macros.svh =====
// ---------------------------------------------------------------------------
// IMA ADPCM block decoder assertion macros
// Shared concurrent assertion forms used by the decoder RTL.
// ---------------------------------------------------------------------------
`ifndef IMA_ADPCM_BLOCK_DECODER_MACROS_SVH
`define IMA_ADPCM_BLOCK_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IMAB_ASSERT_IMP(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IMAB_ASSERT_NXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/imab_pkg.sv =====
// ---------------------------------------------------------------------------
// IMA ADPCM block decoder package
// Widths, constants, the result type and the IMA step and index tables.
// ---------------------------------------------------------------------------
`default_nettype none

package imab_pkg;

  localparam int unsigned MAX_BLOCK_SAMPLES_DEFAULT = 2047;
  localparam int unsigned COUNT_WIDTH = 11;
  localparam int unsigned INDEX_WIDTH = 7;
  localparam int unsigned STEP_WIDTH = 15;
  localparam logic [COUNT_WIDTH-1:0] CAPACITY_RESET = 11'd505;
  localparam logic [INDEX_WIDTH-1:0] MAX_INDEX = 7'd88;
  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [15:0] SAMPLE_MIN = -16'sh8000;
  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_sample;
  } result_t;

  function automatic logic [STEP_WIDTH-1:0] step_size(input logic [INDEX_WIDTH-1:0] idx);
    logic [STEP_WIDTH-1:0] s;
    case (idx)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
      7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
      7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
      7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
      7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
      7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
      7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
      7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
      7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
      7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
      7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
      7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
      7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
      7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
      7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
      7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  function automatic logic signed [7:0] index_adjust(input logic [2:0] mag);
    logic signed [7:0] a;
    case (mag)
      3'd4:    a = 8'sd2;
      3'd5:    a = 8'sd4;
      3'd6:    a = 8'sd6;
      3'd7:    a = 8'sd8;
      default: a = -8'sd1;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/imab_nibble.sv =====
// ---------------------------------------------------------------------------
// IMA ADPCM nibble decoder
// Applies one 4-bit code to the predictor and step index, with saturation.
// ---------------------------------------------------------------------------
`default_nettype none

module imab_nibble
  import imab_pkg::*;
(
  input  logic signed [15:0]            pred_in,
  input  logic [INDEX_WIDTH-1:0]        idx_in,
  input  logic [3:0]                    nib,
  output logic signed [15:0]            pred_out,
  output logic [INDEX_WIDTH-1:0]        idx_out
);

  logic [STEP_WIDTH-1:0]  step;
  logic [16:0]            diff;
  logic signed [17:0]     sum;
  logic signed [7:0]      ni;

  always_comb begin
    step = step_size(idx_in);
    diff = 17'(step >> 3);
    if (nib[0]) begin
      diff = diff + 17'(step >> 2);
    end
    if (nib[1]) begin
      diff = diff + 17'(step >> 1);
    end
    if (nib[2]) begin
      diff = diff + 17'(step);
    end
    if (nib[3]) begin
      sum = 18'(pred_in) - $signed({1'b0, diff});
    end else begin
      sum = 18'(pred_in) + $signed({1'b0, diff});
    end
    if (sum > 18'(SAMPLE_MAX)) begin
      pred_out = SAMPLE_MAX;
    end else if (sum < 18'(SAMPLE_MIN)) begin
      pred_out = SAMPLE_MIN;
    end else begin
      pred_out = sum[15:0];
    end
    ni = $signed({1'b0, idx_in}) + index_adjust(nib[2:0]);
    if (ni < 8'sd0) begin
      idx_out = '0;
    end else if (ni > $signed({1'b0, MAX_INDEX})) begin
      idx_out = MAX_INDEX;
    end else begin
      idx_out = ni[INDEX_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/imab_outq.sv =====
// ---------------------------------------------------------------------------
// IMA ADPCM result queue
// Two-entry output register with skid slot for decoded samples.
// ---------------------------------------------------------------------------
`default_nettype none

module imab_outq
  import imab_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_item,
  output logic    space,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t head
);

  logic [1:0] count;
  logic [1:0] count_next;
  result_t    slot0;
  result_t    slot1;
  logic       pop;

  assign pop = (count != 2'd0) && !out_stall;
  assign space = (count != 2'd2) || pop;
  assign out_valid = (count != 2'd0);
  assign head = slot0;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
    if (count == 2'd2) begin
      if (pop) begin
        slot0 <= slot1;
        if (push) begin
          slot1 <= push_item;
        end
      end
    end else if (count == 2'd1) begin
      if (push && pop) begin
        slot0 <= push_item;
      end else if (push) begin
        slot1 <= push_item;
      end
    end else if (push) begin
      slot0 <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ima_adpcm_block_decoder.sv =====
// ---------------------------------------------------------------------------
// IMA ADPCM block decoder
// Decodes a mono 4-bit IMA ADPCM block streamed one byte per request.
// ---------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  input     in_valid / in_stall  data_byte, block_start, block_end
//  output    out_valid/out_stall  sample, last_sample
//  config    cfg_valid/cfg_ready  cfg_data (sample capacity)
//
//  A header byte retires once the queue has room; a data byte is decoded
//  nibble by nibble in the single nibble decoder, held for its second sample.
//  Results leave through a two-entry queue: one sample per cycle without out_stall.
//  Reset is synchronous; no clearing pass is needed after it.
//  An output stall holds the held byte once the queue is full.
`default_nettype none

module ima_adpcm_block_decoder
  import imab_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_SAMPLES = MAX_BLOCK_SAMPLES_DEFAULT
)
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             data_byte,
  input  logic                   block_start,
  input  logic                   block_end,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [15:0]     sample,
  output logic                   last_sample,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [COUNT_WIDTH-1:0] cfg_data
);

  `include "ima_adpcm_block_decoder_macros.svh"

  localparam int unsigned CountMax = (2 ** COUNT_WIDTH) - 1;
  localparam logic [COUNT_WIDTH-1:0] MaxLimit =
    COUNT_WIDTH'((MAX_BLOCK_SAMPLES > CountMax) ? CountMax : MAX_BLOCK_SAMPLES);

  typedef enum logic [2:0] {
    HP_LOW,
    HP_HIGH,
    HP_INDEX,
    HP_SKIP,
    HP_DATA
  } hdr_pos_t;

  logic [COUNT_WIDTH-1:0] capacity;
  logic [COUNT_WIDTH-1:0] limit;

  logic                   item_full;
  logic [7:0]             item_byte;
  logic                   item_start;
  logic                   item_end;
  logic                   phase;

  hdr_pos_t               hdr_pos;
  hdr_pos_t               hdr_pos_eff;
  hdr_pos_t               hdr_pos_next;
  logic signed [15:0]     predictor;
  logic signed [15:0]     predictor_next;
  logic [INDEX_WIDTH-1:0] step_index;
  logic [INDEX_WIDTH-1:0] step_index_next;
  logic [7:0]             header_low;
  logic [7:0]             header_low_next;
  logic [COUNT_WIDTH-1:0] samples_emitted;
  logic [COUNT_WIDTH-1:0] se_eff;
  logic [COUNT_WIDTH-1:0] se_inc;
  logic [COUNT_WIDTH-1:0] samples_emitted_next;
  logic                   capacity_reached;
  logic                   cr_eff;
  logic                   capacity_reached_next;

  logic                   go;
  logic                   restart;
  logic                   hit;
  logic                   need_second;
  logic                   retire;
  logic [3:0]             nib;
  logic signed [15:0]     nib_pred;
  logic [INDEX_WIDTH-1:0] nib_idx;

  logic                   q_push;
  logic                   q_space;
  result_t                q_item;
  result_t                q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  assign limit = (capacity < MaxLimit) ? capacity : MaxLimit;

  assign go = item_full && q_space;
  assign retire = go && !need_second;
  assign in_stall = item_full && !retire;
  assign restart = !phase && item_start;
  assign nib = phase ? item_byte[7:4] : (item_byte[3:0] & NIBBLE_MASK);

  imab_nibble u_nibble (
    .pred_in  (predictor),
    .idx_in   (step_index),
    .nib      (nib),
    .pred_out (nib_pred),
    .idx_out  (nib_idx)
  );

  always_comb begin
    hdr_pos_eff = restart ? HP_LOW : hdr_pos;
    se_eff = restart ? '0 : samples_emitted;
    if (phase) begin
      cr_eff = capacity_reached;
    end else begin
      cr_eff = (!restart && capacity_reached) || (se_eff >= limit);
    end
    se_inc = se_eff + COUNT_WIDTH'(1);
    hit = (se_inc >= limit);

    hdr_pos_next = hdr_pos_eff;
    predictor_next = predictor;
    step_index_next = step_index;
    header_low_next = header_low;
    samples_emitted_next = se_eff;
    capacity_reached_next = cr_eff;
    need_second = 1'b0;
    q_push = 1'b0;
    q_item.sample = predictor;
    q_item.last_sample = 1'b0;

    unique case (hdr_pos_eff)
      HP_LOW: begin
        header_low_next = item_byte;
        hdr_pos_next = HP_HIGH;
      end
      HP_HIGH: begin
        predictor_next = {item_byte, header_low};
        hdr_pos_next = HP_INDEX;
      end
      HP_INDEX: begin
        step_index_next = (item_byte > 8'(MAX_INDEX)) ? MAX_INDEX
                                                       : item_byte[INDEX_WIDTH-1:0];
        hdr_pos_next = HP_SKIP;
      end
      HP_SKIP: begin
        hdr_pos_next = HP_DATA;
        if (!cr_eff) begin
          samples_emitted_next = se_inc;
          capacity_reached_next = hit;
          q_push = go;
          q_item.sample = predictor;
          q_item.last_sample = hit || item_end;
        end
      end
      HP_DATA: begin
        if (!cr_eff) begin
          predictor_next = nib_pred;
          step_index_next = nib_idx;
          samples_emitted_next = se_inc;
          capacity_reached_next = hit;
          q_push = go;
          q_item.sample = nib_pred;
          q_item.last_sample = hit || (phase && item_end);
          need_second = !phase && !hit;
        end
      end
      default: begin
        hdr_pos_next = HP_LOW;
      end
    endcase

    if (!need_second && item_end) begin
      hdr_pos_next = HP_LOW;
      samples_emitted_next = '0;
      capacity_reached_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
      phase <= 1'b0;
      hdr_pos <= HP_LOW;
      predictor <= '0;
      step_index <= '0;
      header_low <= '0;
      samples_emitted <= '0;
      capacity_reached <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        item_full <= 1'b1;
      end else if (retire) begin
        item_full <= 1'b0;
      end
      if (go) begin
        phase <= need_second;
        hdr_pos <= hdr_pos_next;
        predictor <= predictor_next;
        step_index <= step_index_next;
        header_low <= header_low_next;
        samples_emitted <= samples_emitted_next;
        capacity_reached <= capacity_reached_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_byte <= data_byte;
      item_start <= block_start;
      item_end <= block_end;
    end
  end

  imab_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .space     (q_space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (q_head)
  );

  assign sample = q_head.sample;
  assign last_sample = q_head.last_sample;

  `IMAB_ASSERT_IMP(a_index_range, clk, rst, 1'b1, step_index <= MAX_INDEX,
                   "Step index left the table range.")
  `IMAB_ASSERT_IMP(a_phase_holds_item, clk, rst, phase, item_full,
                   "Second nibble pending without a held byte.")
  `IMAB_ASSERT_IMP(a_push_has_room, clk, rst, q_push, q_space,
                   "Sample pushed into a full result queue.")
  `IMAB_ASSERT_NXT(a_second_follows, clk, rst, go && need_second,
                   phase && item_full && (hdr_pos == HP_DATA),
                   "High nibble did not follow the low nibble.")

endmodule

`default_nettype wire
